// ----- hw/rtl/nacc_pkg.sv -----
// Shared types and constants for the NNUE accumulator update block.
// No dependencies; used by nacc_lane, nacc_read_sel and nnue_accumulator_update.
package nacc_pkg;

  // Default sizes, handed down through the top level parameters
  localparam int ACC_LEN_DEF      = 64;
  localparam int NUM_FEATURES_DEF = 1024;

  // Fixed field widths
  localparam int ACTION_W   = 3;
  localparam int FEATURE_W  = 10;
  localparam int GROUP_W    = 4;
  localparam int PAYLOAD_W  = 64;
  localparam int WEIGHT_W   = 8;
  localparam int LANE_W     = 16;

  // Lanes moved by one weight write and by one bias write / read
  localparam int WEIGHTS_PER_WRITE = PAYLOAD_W / WEIGHT_W;
  localparam int LANES_PER_WORD    = PAYLOAD_W / LANE_W;

  // Action codes carried on the input channel
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_WEIGHTS = 3'd0,
    ACT_WRITE_BIAS    = 3'd1,
    ACT_REFRESH       = 3'd2,
    ACT_ADD           = 3'd3,
    ACT_REMOVE        = 3'd4,
    ACT_READ          = 3'd5
  } action_t;

  // Per-lane accumulator operation
  typedef enum logic [1:0] {
    LANE_HOLD,
    LANE_LOAD,
    LANE_ADD,
    LANE_SUB
  } lane_op_t;

  // Control bundle sent to each lane
  typedef struct packed {
    lane_op_t op;
    logic     bias_we;
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/nacc_ram.sv -----
// Generic single-port RAM with registered read and read enable.
// No dependencies; used for the weight table banks.
module nacc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read, read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/nacc_lane.sv -----
// One accumulator lane: bias register, accumulator register and adder.
// Depends on nacc_pkg.
module nacc_lane import nacc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  lane_ctrl_t          ctrl,
  input  logic [LANE_W-1:0]   bias_wdata,
  input  logic [WEIGHT_W-1:0] weight,
  output logic [LANE_W-1:0]   acc
);

  logic [LANE_W-1:0] bias;
  logic [LANE_W-1:0] weight_ext;

  // Sign-extend the int8 weight to lane width
  assign weight_ext = {{(LANE_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};

  // Bias store and wrapping accumulator update
  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
      acc  <= '0;
    end else begin
      if (ctrl.bias_we) begin
        bias <= bias_wdata;
      end
      case (ctrl.op)
        LANE_LOAD: acc <= bias;
        LANE_ADD:  acc <= acc + weight_ext;
        LANE_SUB:  acc <= acc - weight_ext;
        default:   acc <= acc;
      endcase
    end
  end

endmodule

// ----- hw/rtl/nacc_read_sel.sv -----
// Merge stage: picks the four accumulator lanes of one lane group.
// Depends on nacc_pkg.
module nacc_read_sel import nacc_pkg::*; #(
  parameter int ACC_LEN = ACC_LEN_DEF
) (
  input  logic [ACC_LEN-1:0][LANE_W-1:0] acc_lanes,
  input  logic [GROUP_W-1:0]             group,
  output logic [PAYLOAD_W-1:0]           data
);

  localparam int NUM_WORDS = (ACC_LEN + LANES_PER_WORD - 1) / LANES_PER_WORD;

  // Group decode; lanes past ACC_LEN read as zero
  always_comb begin
    data = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (int'(group) == w) begin
        for (int k = 0; k < LANES_PER_WORD; k++) begin
          if (w * LANES_PER_WORD + k < ACC_LEN) begin
            data[k*LANE_W +: LANE_W] = acc_lanes[w*LANES_PER_WORD + k];
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/nnue_accumulator_update.sv -----
// NNUE accumulator with incremental update: top level.
// Depends on nacc_pkg, nacc_ram, nacc_lane and nacc_read_sel.
//
// Takes one item per clock unless out_ready stalls it and returns one result
// per item, in order. Every item passes two stages: on transfer the weight row
// is read (or eight weights written) in ACC_LEN/8 banks of 64-bit RAM, one bank
// per group of eight lanes; when the item leaves the second stage, all ACC_LEN
// lanes update in parallel and the result enters the output register, which
// raises out_valid. in_ready follows out_ready through the two stages, so the
// sustained rate is one item per cycle with out_ready held high; with out_ready
// low the block holds two items and then stalls its input. in_ready is low
// during reset. The weight table is undefined until written and needs no
// clearing pass; bias and accumulator lanes clear at reset.
module nnue_accumulator_update import nacc_pkg::*; #(
  parameter int ACC_LEN      = ACC_LEN_DEF,
  parameter int NUM_FEATURES = NUM_FEATURES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [FEATURE_W-1:0] feature_index,
  input  logic [GROUP_W-1:0]   lane_group,
  input  logic [PAYLOAD_W-1:0] payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PAYLOAD_W-1:0] read_data,
  output logic                 read_valid
);

  localparam int NUM_BANKS = (ACC_LEN + WEIGHTS_PER_WRITE - 1) / WEIGHTS_PER_WRITE;
  localparam int ADDR_W    = $clog2(NUM_FEATURES);

  // Handshake
  logic in_fire;
  logic s1_fire;

  // Second stage registers
  logic                 s1_valid;
  logic [ACTION_W-1:0]  s1_action;
  logic [GROUP_W-1:0]   s1_group;
  logic [PAYLOAD_W-1:0] s1_payload;
  logic                 s1_feat_ok;

  logic                 feat_ok;
  logic [ADDR_W-1:0]    ram_addr;
  logic [NUM_BANKS-1:0][PAYLOAD_W-1:0] bank_rdata;
  logic [ACC_LEN-1:0][LANE_W-1:0]      acc_lanes;
  logic [PAYLOAD_W-1:0] sel_data;
  lane_op_t             lane_op;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || s1_fire);
  assign in_fire  = in_valid && in_ready;

  assign feat_ok  = int'(feature_index) < NUM_FEATURES;
  assign ram_addr = ADDR_W'(feature_index);

  // Weight banks, one per group of eight lanes
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic bank_we;
    assign bank_we = in_fire && (action == ACT_WRITE_WEIGHTS) && feat_ok &&
                     (int'(lane_group) == b);
    nacc_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (NUM_FEATURES)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we),
      .re    (in_fire),
      .addr  (ram_addr),
      .wdata (payload),
      .rdata (bank_rdata[b])
    );
  end

  // First-to-second stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_action  <= action;
      s1_group   <= lane_group;
      s1_payload <= payload;
      s1_feat_ok <= feat_ok;
    end
  end

  // Lane operation, applied once when the item leaves the second stage
  always_comb begin
    lane_op = LANE_HOLD;
    if (s1_fire) begin
      case (s1_action)
        ACT_REFRESH: lane_op = LANE_LOAD;
        ACT_ADD:     lane_op = s1_feat_ok ? LANE_ADD : LANE_HOLD;
        ACT_REMOVE:  lane_op = s1_feat_ok ? LANE_SUB : LANE_HOLD;
        default:     lane_op = LANE_HOLD;
      endcase
    end
  end

  // Accumulator lanes
  for (genvar i = 0; i < ACC_LEN; i++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl.op      = lane_op;
    assign ctrl.bias_we = s1_fire && (s1_action == ACT_WRITE_BIAS) &&
                          (int'(s1_group) == i / LANES_PER_WORD);
    nacc_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .bias_wdata (s1_payload[(i % LANES_PER_WORD)*LANE_W +: LANE_W]),
      .weight     (bank_rdata[i / WEIGHTS_PER_WRITE]
                             [(i % WEIGHTS_PER_WRITE)*WEIGHT_W +: WEIGHT_W]),
      .acc        (acc_lanes[i])
    );
  end

  // Read merge
  nacc_read_sel #(
    .ACC_LEN (ACC_LEN)
  ) u_read_sel (
    .acc_lanes (acc_lanes),
    .group     (s1_group),
    .data      (sel_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire) begin
      read_valid <= (s1_action == ACT_READ);
      read_data  <= (s1_action == ACT_READ) ? sel_data : '0;
    end
  end

`ifndef SYNTHESIS
  // A non-read result carries zero data
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_data == '0)
    else $error("non-read result with non-zero data");

  // A stalled second stage keeps its item
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_action) && $stable(s1_group))
    else $error("second stage lost its item while stalled");

  // An empty second stage never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input blocked with empty pipeline");
`endif

endmodule
